[src/stug_pkg.sv]
// Package for the sine tone mu-law generator: constants, register codes and the sine ROM.
package stug_pkg;

    localparam int BLOCK_LEN   = 200;
    localparam int PHASE_STEPS = 8000;
    localparam int QUARTER     = 2000;

    localparam int PHASE_W  = $clog2(PHASE_STEPS);
    localparam int BPOS_W   = 8;
    localparam int FREQ_W   = 12;
    localparam int AMP_W    = 15;
    localparam int SINE_W   = 15;
    localparam int ROM_AW   = $clog2(QUARTER + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [FREQ_W-1:0] TONE_FREQ_RST = FREQ_W'(1000);
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST = AMP_W'(8192);

    localparam logic [14:0] MU_CLIP = 15'd32635;
    localparam logic [14:0] MU_BIAS = 15'h0084;
    localparam logic [7:0]  MU_SIGN = 8'h80;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TONE_FREQ = 1'b0,
        REG_AMPLITUDE = 1'b1
    } t_cfg_reg;

    typedef logic [SINE_W-1:0] t_sine_rom [QUARTER+1];

    // Quarter-wave sine in unsigned Q0.15 from a truncated Taylor series in Q2.30.
    // The extra entry at the end is the peak and reads as full scale.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint sum;
        longint unsigned v;
        for (int i = 0; i < QUARTER; i++) begin
            x   = (longint'(i) * HALF_PI_Q30) / QUARTER;
            x2  = (x * x) >> 30;
            t   = x;
            sum = longint'(x);
            t = ((t * x2) >> 30) / 6;   sum = sum - longint'(t);
            t = ((t * x2) >> 30) / 20;  sum = sum + longint'(t);
            t = ((t * x2) >> 30) / 42;  sum = sum - longint'(t);
            t = ((t * x2) >> 30) / 72;  sum = sum + longint'(t);
            t = ((t * x2) >> 30) / 110; sum = sum - longint'(t);
            t = ((t * x2) >> 30) / 156; sum = sum + longint'(t);
            if (sum < 0) begin
                sum = 0;
            end
            v = (longint'(sum) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[i] = SINE_W'(v);
        end
        rom[QUARTER] = SINE_W'(32767);
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

[src/sine_tone_ulaw_generator.sv]
// Sine tone generator with mu-law output: phase state, ROM, scaling and encoding pipeline.
//
//  channel | valid   | ready   | payload                    | word
//  --------+---------+---------+----------------------------+------------------------
//  input   | i_valid | o_ready | i_restart                  | one sample request
//  output  | o_valid | i_ready | o_ulaw_byte, o_block_last  | one mu-law tone sample
//  config  | i_cfg_wr_en       | i_cfg_index, i_cfg_data    | one register write
//
// One word is accepted per cycle while o_ready is high; each stage below is registered.
// The stages are phase/quadrant select, sine ROM read, amplitude multiply, and mu-law encode.
// Synchronous active-low reset clears phase, block position, valid bits; presets registers.
// Each stage holds only while the one after it is full and stalled, so a stalled
// output still lets new words enter until every stage is occupied.
module sine_tone_ulaw_generator
    import stug_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_ulaw_byte,
    output logic                  o_block_last
);

    logic [FREQ_W-1:0]  r_tone_freq;
    logic [AMP_W-1:0]   r_amplitude;
    logic [PHASE_W-1:0] r_phase;
    logic [BPOS_W-1:0]  r_block_pos;

    logic               r_s1_valid;
    logic [ROM_AW-1:0]  r_s1_addr;
    logic               r_s1_neg;
    logic               r_s1_last;
    logic               r_s2_valid;
    logic [SINE_W-1:0]  r_s2_sine;
    logic               r_s2_neg;
    logic               r_s2_last;
    logic               r_s3_valid;
    logic [14:0]        r_s3_mag;
    logic               r_s3_neg;
    logic               r_s3_last;
    logic               r_out_valid;
    logic [7:0]         r_ulaw;
    logic               r_last;

    logic               en1;
    logic               en2;
    logic               en3;
    logic               en_out;
    logic               accept;

    logic [PHASE_W-1:0] base_phase;
    logic [BPOS_W-1:0]  base_pos;
    logic               cur_last;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W-1:0] n_phase;
    logic [BPOS_W-1:0]  n_block_pos;
    logic [ROM_AW-1:0]  n_addr;
    logic               n_neg;
    logic [29:0]        product;

    function automatic logic [7:0] mulaw_encode(input logic neg, input logic [14:0] mag);
        logic [14:0] clip;
        logic [14:0] biased;
        logic [7:0]  v;
        logic [2:0]  e;
        logic [14:0] shifted;
        clip   = (mag > MU_CLIP) ? MU_CLIP : mag;
        biased = clip + MU_BIAS;
        v      = biased[14:7];
        priority if (v[7]) e = 3'd7;
        else if (v[6])     e = 3'd6;
        else if (v[5])     e = 3'd5;
        else if (v[4])     e = 3'd4;
        else if (v[3])     e = 3'd3;
        else if (v[2])     e = 3'd2;
        else if (v[1])     e = 3'd1;
        else               e = 3'd0;
        shifted = biased >> ({1'b0, e} + 4'd3);
        return ~((neg ? MU_SIGN : 8'h00) | {1'b0, e, shifted[3:0]});
    endfunction

    assign en_out = !r_out_valid || i_ready;
    assign en3    = !r_s3_valid || en_out;
    assign en2    = !r_s2_valid || en3;
    assign en1    = !r_s1_valid || en2;
    assign o_ready = en1;
    assign accept  = i_valid && en1;

    // Phase and block position as seen by this sample, then the state after it.
    always_comb begin
        base_phase = i_restart ? '0 : r_phase;
        base_pos   = i_restart ? '0 : r_block_pos;
        cur_last   = (base_pos == BPOS_W'(BLOCK_LEN - 1));
        phase_sum  = {1'b0, base_phase} + (PHASE_W+1)'(r_tone_freq);
        n_phase    = (phase_sum >= (PHASE_W+1)'(PHASE_STEPS))
                     ? PHASE_W'(phase_sum - (PHASE_W+1)'(PHASE_STEPS))
                     : phase_sum[PHASE_W-1:0];
        n_block_pos = cur_last ? '0 : base_pos + 1'b1;
    end

    // The phase runs over 8000 steps, which is also the angle scale, so it picks
    // quadrant and ROM address directly. Odd quadrants read the table mirrored.
    always_comb begin
        if (base_phase < PHASE_W'(QUARTER)) begin
            n_addr = ROM_AW'(base_phase);
            n_neg  = 1'b0;
        end else if (base_phase < PHASE_W'(2 * QUARTER)) begin
            n_addr = ROM_AW'(PHASE_W'(2 * QUARTER) - base_phase);
            n_neg  = 1'b0;
        end else if (base_phase < PHASE_W'(3 * QUARTER)) begin
            n_addr = ROM_AW'(base_phase - PHASE_W'(2 * QUARTER));
            n_neg  = 1'b1;
        end else begin
            n_addr = ROM_AW'(PHASE_W'(4 * QUARTER) - base_phase);
            n_neg  = 1'b1;
        end
    end

    assign product = r_s2_sine * r_amplitude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_freq <= TONE_FREQ_RST;
            r_amplitude <= AMPLITUDE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_TONE_FREQ: r_tone_freq <= i_cfg_data[FREQ_W-1:0];
                REG_AMPLITUDE: r_amplitude <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_block_pos <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_block_pos <= n_block_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1)    r_s1_valid  <= accept;
            if (en2)    r_s2_valid  <= r_s1_valid;
            if (en3)    r_s3_valid  <= r_s2_valid;
            if (en_out) r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_addr <= n_addr;
            r_s1_neg  <= n_neg;
            r_s1_last <= cur_last;
        end
        if (en2) begin
            r_s2_sine <= SINE_ROM[r_s1_addr];
            r_s2_neg  <= r_s1_neg;
            r_s2_last <= r_s1_last;
        end
        if (en3) begin
            r_s3_mag  <= product[29:15];
            // A product that truncates to zero is encoded as positive zero.
            r_s3_neg  <= r_s2_neg && (product[29:15] != '0);
            r_s3_last <= r_s2_last;
        end
        if (en_out) begin
            r_ulaw <= mulaw_encode(r_s3_neg, r_s3_mag);
            r_last <= r_s3_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ulaw_byte  = r_ulaw;
    assign o_block_last = r_last;

endmodule

[src/stug_chk.sv]
// Port-level checker for the sine tone mu-law generator and its bind.
module stug_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_ulaw_byte,
    input logic       o_block_last
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // With no result waiting, nothing downstream can block the input.
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready while output is empty");

    // A word accepted while the output keeps draining moves through every stage register
    // and is then seen as a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("result missing after four free-running cycles");

    // A stalled result holds its word.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ulaw_byte) && $stable(o_block_last))
        else $error("stalled result changed");

endmodule

bind sine_tone_ulaw_generator stug_chk u_stug_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_ulaw_byte  (o_ulaw_byte),
    .o_block_last (o_block_last)
);
